// ----- rtl/core/tkc_pkg.sv -----
// shared types and constants for the top-k by count keeper
`timescale 1ns / 1ps
`default_nettype none
package tkc_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int ID_W          = 32;
    localparam int CNT_W         = 32;
    localparam int RANK_W        = 4;
    localparam int CFG_W         = 5;

    localparam logic [CFG_W-1:0] KEEP_RESET = CFG_W'(16);

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_READOUT = 1'b1;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_HOLD   = 2'd0;
    localparam t_mode MODE_INSERT = 2'd1;
    localparam t_mode MODE_TRIM   = 2'd2;
    localparam t_mode MODE_POP    = 2'd3;

    typedef struct packed {
        logic             valid;
        logic [ID_W-1:0]  id;
        logic [CNT_W-1:0] count;
    } t_cell_data;

    localparam t_cell_data CELL_EMPTY = '{valid: 1'b0, id: '0, count: '0};

endpackage
`default_nettype wire

// ----- rtl/core/tkc_in_if.sv -----
// input channel: command and entry offered for ranking
`timescale 1ns / 1ps
`default_nettype none
interface tkc_in_if;
    import tkc_pkg::*;

    logic             valid;
    logic             ready;
    logic             cmd;
    logic [ID_W-1:0]  entry_id;
    logic [CNT_W-1:0] entry_count;

    modport source (output valid, output cmd, output entry_id, output entry_count,
                    input ready);
    modport sink   (input valid, input cmd, input entry_id, input entry_count,
                    output ready);
endinterface
`default_nettype wire

// ----- rtl/core/tkc_out_if.sv -----
// output channel: one ranked entry per transfer
`timescale 1ns / 1ps
`default_nettype none
interface tkc_out_if;
    import tkc_pkg::*;

    logic              valid;
    logic              ready;
    logic [RANK_W-1:0] rank;
    logic [ID_W-1:0]   ranked_id;
    logic [CNT_W-1:0]  ranked_count;
    logic              last_of_list;
    logic              list_empty;

    modport source (output valid, output rank, output ranked_id, output ranked_count,
                    output last_of_list, output list_empty, input ready);
    modport sink   (input valid, input rank, input ranked_id, input ranked_count,
                    input last_of_list, input list_empty, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/tkc_cell.sv -----
// one slot of the ranked list: compare, insert, shift down, shift up or trim
`timescale 1ns / 1ps
`default_nettype none
module tkc_cell (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire tkc_pkg::t_mode           i_mode,
    input  wire logic                     i_in_range,
    input  wire logic [tkc_pkg::ID_W-1:0] i_new_id,
    input  wire logic [tkc_pkg::CNT_W-1:0] i_new_count,
    input  wire tkc_pkg::t_cell_data      i_prev,
    input  wire logic                     i_prev_before,
    input  wire tkc_pkg::t_cell_data      i_next,
    output tkc_pkg::t_cell_data           o_data,
    output logic                          o_before
);
    import tkc_pkg::*;

    logic             r_valid;
    logic [ID_W-1:0]  r_id;
    logic [CNT_W-1:0] r_count;
    t_cell_data       n_data;
    t_cell_data       w_cur;

    assign w_cur    = '{valid: r_valid, id: r_id, count: r_count};
    assign o_data   = w_cur;
    // new entry ranks ahead of this slot (or this slot is free)
    assign o_before = !(r_valid && i_in_range) || (r_count < i_new_count);

    always_comb begin
        n_data = w_cur;
        unique case (i_mode)
            MODE_INSERT: begin
                if (!i_in_range) begin
                    n_data.valid = 1'b0;
                end else if (i_prev_before) begin
                    n_data = i_prev;
                end else if (o_before) begin
                    n_data = '{valid: 1'b1, id: i_new_id, count: i_new_count};
                end
            end
            MODE_TRIM: n_data.valid = r_valid & i_in_range;
            MODE_POP:  n_data = i_next;
            default:   n_data = w_cur;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_data.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id    <= n_data.id;
        r_count <= n_data.count;
    end

endmodule
`default_nettype wire

// ----- rtl/core/top_k_by_count_keeper.sv -----
// top level: row of list cells, readout sequencer and output register
//
// Keeps the top keep_count entries by descending count (ties keep arrival
// order) in a row of DEPTH cells. Input channel i_in carries insert and
// readout commands; output channel o_out carries one ranked entry per transfer.
// On an insert, every cell compares its count against the new one in
// parallel and the row shifts down behind the insertion point, so inserts
// stream at one per cycle while no readout is in progress, with no result.
// A readout trims the row to the current limit on the edge that takes it, then
// pops one entry per cycle, unless the receiver stalls, from the head of the
// row into the output register: n stored entries give n transfers (an empty
// list gives one empty-flag transfer), with the final one marked last. i_in
// is not ready until the last entry of a readout is in the output register;
// a stalled output simply holds the register and the row. keep_count is
// written on i_cfg_we.
// Reset clears every cell valid bit, the sequencer and the output valid, and
// sets keep_count to 16.
`timescale 1ns / 1ps
`default_nettype none
module top_k_by_count_keeper #(
    parameter int DEPTH = tkc_pkg::DEPTH_DEFAULT
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [tkc_pkg::CFG_W-1:0] i_cfg_wdata,
    tkc_in_if.sink                         i_in,
    tkc_out_if.source                      o_out
);
    import tkc_pkg::*;

    localparam int LIM_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (LIM_W > CFG_W) ? LIM_W : CFG_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    logic [CFG_W-1:0]  r_keep;
    logic              r_state, n_state;
    logic [RANK_W-1:0] r_rank;
    logic              r_out_valid;
    logic [RANK_W-1:0] r_out_rank;
    logic [ID_W-1:0]   r_out_id;
    logic [CNT_W-1:0]  r_out_count;
    logic              r_out_last;
    logic              r_out_empty;

    logic [CMP_W-1:0]  w_keep_ext;
    logic [CMP_W-1:0]  w_limit;
    logic              w_in_fire;
    logic              w_out_load;
    logic              w_head_last;
    t_mode             w_mode;
    t_cell_data        w_cell   [DEPTH];
    logic [DEPTH-1:0]  w_before;
    logic [DEPTH-1:0]  w_in_range;
    logic [DEPTH-1:0]  w_valid_vec;

    // keep_count of 0 acts as 1, above DEPTH acts as DEPTH
    assign w_keep_ext = CMP_W'(r_keep);
    always_comb begin
        if (w_keep_ext == '0) begin
            w_limit = CMP_W'(1);
        end else if (w_keep_ext > CMP_W'(DEPTH)) begin
            w_limit = CMP_W'(DEPTH);
        end else begin
            w_limit = w_keep_ext;
        end
    end

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_out_load = (r_state == ST_DUMP) && (!r_out_valid || o_out.ready);

    always_comb begin
        if (w_in_fire && (i_in.cmd == CMD_INSERT)) begin
            w_mode = MODE_INSERT;
        end else if (w_in_fire) begin
            w_mode = MODE_TRIM;
        end else if (w_out_load && w_cell[0].valid) begin
            w_mode = MODE_POP;
        end else begin
            w_mode = MODE_HOLD;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_data w_prev;
        t_cell_data w_next;
        logic       w_prev_before;

        assign w_in_range[g]  = (CMP_W'(g) < w_limit);
        assign w_valid_vec[g] = w_cell[g].valid;

        if (g == 0) begin : g_head
            assign w_prev        = CELL_EMPTY;
            assign w_prev_before = 1'b0;
        end else begin : g_body
            assign w_prev        = w_cell[g-1];
            assign w_prev_before = w_before[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_next = CELL_EMPTY;
        end else begin : g_mid
            assign w_next = w_cell[g+1];
        end

        tkc_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_mode        (w_mode),
            .i_in_range    (w_in_range[g]),
            .i_new_id      (i_in.entry_id),
            .i_new_count   (i_in.entry_count),
            .i_prev        (w_prev),
            .i_prev_before (w_prev_before),
            .i_next        (w_next),
            .o_data        (w_cell[g]),
            .o_before      (w_before[g])
        );
    end

    // after the trim, the head is the last entry when its neighbor is empty
    if (DEPTH > 1) begin : g_last_multi
        assign w_head_last = !w_cell[1].valid;
    end else begin : g_last_single
        assign w_head_last = 1'b1;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_fire && (i_in.cmd == CMD_READOUT)) begin
                    n_state = ST_DUMP;
                end
            end
            ST_DUMP: begin
                if (w_out_load && (!w_cell[0].valid || w_head_last)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep      <= KEEP_RESET;
            r_state     <= ST_IDLE;
            r_rank      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_keep <= i_cfg_wdata;
            end
            r_state <= n_state;
            if (w_mode == MODE_TRIM) begin
                r_rank <= '0;
            end else if (w_out_load) begin
                r_rank <= r_rank + RANK_W'(1);
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            if (w_cell[0].valid) begin
                r_out_rank  <= r_rank;
                r_out_id    <= w_cell[0].id;
                r_out_count <= w_cell[0].count;
                r_out_last  <= w_head_last;
                r_out_empty <= 1'b0;
            end else begin
                r_out_rank  <= '0;
                r_out_id    <= '0;
                r_out_count <= '0;
                r_out_last  <= 1'b1;
                r_out_empty <= 1'b1;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.rank         = r_out_rank;
    assign o_out.ranked_id    = r_out_id;
    assign o_out.ranked_count = r_out_count;
    assign o_out.last_of_list = r_out_last;
    assign o_out.list_empty   = r_out_empty;

    // filled cells always form a prefix of the row
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid_vec & (w_valid_vec + DEPTH'(1))) == '0)
        else $error("cell valid bits are not a contiguous prefix");

    // an empty readout result is always the last one of its readout
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.list_empty) |-> o_out.last_of_list)
        else $error("empty-list result not marked last");

    // loading the last entry of a readout ends the readout and empties the row
    a_last_ends_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && (!w_cell[0].valid || w_head_last))
        |=> (r_state == ST_IDLE) && (w_valid_vec == '0))
        else $error("readout did not finish with an empty row");

endmodule
`default_nettype wire

// ----- test/top_k_by_count_keeper_test.sv -----
// testbench for the top-k by count keeper: directed and random streams against a predictor
`timescale 1ns / 1ps
module top_k_by_count_keeper_test;
    import tkc_pkg::*;

    localparam int ROWS         = DEPTH_DEFAULT;
    localparam int QUIET_MAX    = 2000;
    localparam int RANDOM_ITEMS = 310;
    localparam int CALM_TAIL    = 60;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [ID_W-1:0]   id;
        logic [CNT_W-1:0]  count;
        logic              last;
        logic              empty;
    } t_ranked_entry;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    tkc_in_if  entry_ch ();
    tkc_out_if ranked_ch ();

    top_k_by_count_keeper #(.DEPTH(ROWS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (entry_ch),
        .o_out       (ranked_ch)
    );

    // predicted contents of the ranked list
    logic [ID_W-1:0]  row_ids    [ROWS];
    logic [CNT_W-1:0] row_counts [ROWS];
    int               row_fill;
    logic [CFG_W-1:0] keep_reg;
    t_ranked_entry    expected_ranks [$];

    int items_sent;
    int mismatches;
    int quiet_cycles = 0;
    bit idle_on;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // zero reads as one, anything above the row size reads as the row size
    function automatic int keep_limit();
        int k;
        k = int'(keep_reg);
        if (k == 0) k = 1;
        if (k > ROWS) k = ROWS;
        return k;
    endfunction

    function automatic void rank_insert(logic [ID_W-1:0] id, logic [CNT_W-1:0] cnt);
        int k;
        int n;
        int pos;
        k = keep_limit();
        n = (row_fill < k) ? row_fill : k;
        pos = n;
        // first entry with a strictly smaller count, so ties keep arrival order
        for (int i = n - 1; i >= 0; i--) begin
            if (row_counts[i] < cnt) pos = i;
        end
        if (pos >= k) begin
            row_fill = n;
            return;
        end
        for (int i = (n < k) ? n : k - 1; i > pos; i--) begin
            row_ids[i]    = row_ids[i-1];
            row_counts[i] = row_counts[i-1];
        end
        row_ids[pos]    = id;
        row_counts[pos] = cnt;
        row_fill = (n + 1 < k) ? n + 1 : k;
    endfunction

    function automatic void rank_readout();
        int n;
        t_ranked_entry r;
        n = (row_fill < keep_limit()) ? row_fill : keep_limit();
        if (n == 0) begin
            r = '{rank: '0, id: '0, count: '0, last: 1'b1, empty: 1'b1};
            expected_ranks.push_back(r);
        end
        for (int i = 0; i < n; i++) begin
            r.rank  = RANK_W'(i);
            r.id    = row_ids[i];
            r.count = row_counts[i];
            r.last  = (i == n - 1);
            r.empty = 1'b0;
            expected_ranks.push_back(r);
        end
        row_fill = 0;
    endfunction

    function automatic logic [CNT_W-1:0] draw_count();
        case ($urandom_range(0, 3))
            0:       return CNT_W'($urandom_range(0, 7));
            1:       return $urandom_range(0, 1) ? '1 : '0;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(logic cmd, logic [ID_W-1:0] id, logic [CNT_W-1:0] cnt);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            entry_ch.valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        entry_ch.valid       = 1'b1;
        entry_ch.cmd         = cmd;
        entry_ch.entry_id    = id;
        entry_ch.entry_count = cnt;
        @(posedge i_clk);
        while (!entry_ch.ready) @(posedge i_clk);
        items_sent++;
        if (cmd == CMD_INSERT) rank_insert(id, cnt);
        else rank_readout();
    endtask

    task automatic insert(logic [ID_W-1:0] id, logic [CNT_W-1:0] cnt);
        send_item(CMD_INSERT, id, cnt);
    endtask

    // entry fields are don't-care on a readout, so fill them with noise
    task automatic readout();
        send_item(CMD_READOUT, $urandom, $urandom);
    endtask

    task automatic settle();
        @(negedge i_clk);
        entry_ch.valid = 1'b0;
        while (expected_ranks.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_keep(logic [CFG_W-1:0] value);
        settle();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        keep_reg = value;
    endtask

    task automatic test_empty_readout();
        readout();
        readout();
    endtask

    task automatic test_single_slot();
        write_keep(CFG_W'(0));
        insert('1, '0);
        insert('0, '1);
        insert(32'h0000_1234, '1);
        readout();
    endtask

    task automatic test_ties_and_discard();
        write_keep(CFG_W'(3));
        insert(32'h0000_00a0, 5);
        insert(32'h0000_00b0, 5);
        insert(32'h0000_00c0, 7);
        insert(32'h0000_00d0, 1);
        insert(32'h0000_00e0, 5);
        insert(32'h0000_00f0, 6);
        readout();
    endtask

    task automatic test_limit_changes();
        write_keep(CFG_W'(31));
        for (int i = 1; i <= 4; i++) insert(ID_W'(32'h10 + i), CNT_W'(i));
        write_keep(CFG_W'(2));
        readout();
        // lowered and raised again with no insert in between: entries come back
        insert(32'h0000_0021, 9);
        insert(32'h0000_0022, 8);
        insert(32'h0000_0023, 7);
        write_keep(CFG_W'(1));
        write_keep(CFG_W'(17));
        readout();
        // an insert under a lowered limit trims the list for good
        insert(32'h0000_0031, 3);
        insert(32'h0000_0032, 2);
        insert(32'h0000_0033, 1);
        write_keep(CFG_W'(2));
        insert(32'h0000_0034, 0);
        write_keep(CFG_W'(16));
        readout();
    endtask

    task automatic test_random_stream();
        int start;
        int burst;
        logic [CFG_W-1:0] keep_pick;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            if (items_sent - start > RANDOM_ITEMS - CALM_TAIL) idle_on = 1'b0;
            else idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 5))
                    0:       keep_pick = CFG_W'(0);
                    1:       keep_pick = CFG_W'(1);
                    2:       keep_pick = CFG_W'(16);
                    3:       keep_pick = CFG_W'(31);
                    default: keep_pick = CFG_W'($urandom_range(0, 31));
                endcase
                write_keep(keep_pick);
            end
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 24) : $urandom_range(0, 12);
            repeat (burst) insert($urandom, draw_count());
            readout();
            if ($urandom_range(0, 7) == 0) readout();
        end
    endtask

    initial begin
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_wdata          = '0;
        entry_ch.valid       = 1'b0;
        entry_ch.cmd         = CMD_INSERT;
        entry_ch.entry_id    = '0;
        entry_ch.entry_count = '0;
        keep_reg             = KEEP_RESET;
        row_fill             = 0;
        items_sent           = 0;
        mismatches           = 0;
        idle_on              = 1'b1;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_readout();
        test_single_slot();
        test_ties_and_discard();
        test_limit_changes();
        test_random_stream();
        settle();

        if (mismatches == 0 && expected_ranks.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // receiver side: stall bursts while idling is on
    initial begin
        ranked_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                ranked_ch.ready = 1'b0;
                repeat ($urandom_range(1, 11) - 1) @(negedge i_clk);
            end else begin
                ranked_ch.ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : score
        t_ranked_entry got;
        t_ranked_entry want;
        if (i_rst_n && ranked_ch.valid && ranked_ch.ready) begin
            got = '{rank: ranked_ch.rank, id: ranked_ch.ranked_id,
                    count: ranked_ch.ranked_count, last: ranked_ch.last_of_list,
                    empty: ranked_ch.list_empty};
            if (expected_ranks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: rank %0d id %h count %h last %b empty %b",
                             got.rank, got.id, got.count, got.last, got.empty);
            end else begin
                want = expected_ranks.pop_front();
                if (got.rank !== want.rank || got.id !== want.id || got.count !== want.count ||
                    got.last !== want.last || got.empty !== want.empty) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected rank %0d id %h count %h last %b empty %b",
                                 want.rank, want.id, want.count, want.last, want.empty);
                        $display("          actual   rank %0d id %h count %h last %b empty %b",
                                 got.rank, got.id, got.count, got.last, got.empty);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (entry_ch.valid && entry_ch.ready) ||
            (ranked_ch.valid && ranked_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_MAX) begin
            $display("no transfer for %0d cycles", QUIET_MAX);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
